// ----- hw/rtl/three_factor_plasticity_update_macros.svh -----
// Assertion macros shared by the plasticity update RTL.
`ifndef THREE_FACTOR_PLASTICITY_UPDATE_MACROS_SVH
`define THREE_FACTOR_PLASTICITY_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define TFPU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfpu: same-cycle check failed");
`define TFPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfpu: next-cycle check failed");
`else
`define TFPU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define TFPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/tfpu_pkg.sv -----
// Constants shared by the plasticity update block.
package tfpu_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_TRACE_DECAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOMEO_MAX   = 3'd4;

    localparam logic [16:0] TRACE_DECAY_RST = 17'd58982;
    localparam logic [15:0] LEARN_RATE_RST  = 16'd655;
    localparam logic [15:0] DECAY_RATE_RST  = 16'd0;
    localparam logic [14:0] CLIP_LIMIT_RST  = 15'd4096;
    localparam logic [14:0] HOMEO_MAX_RST   = 15'd4096;

    // item function codes
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    // arithmetic constants
    localparam logic [16:0] DECAY_ONE = 17'd65536;
    localparam logic [14:0] MIN_BOUND = 15'd1024;

    // front layout: input, divider set-up, 17 divider steps, gate, rate, reward product
    localparam int DIV_LAST   = 17;
    localparam int GATE_STAGE = 18;
    localparam int RATE_STAGE = 19;
    localparam int MR_STAGE   = 20;
    localparam int FRONT_N    = 22;

endpackage

// ----- hw/rtl/three_factor_plasticity_update.sv -----
// One item per cycle is taken unless result_stall or a read-after-write hold stalls it.
// An update whose synapse is still in the five-stage memory read-modify-write section
// waits at the memory issue stage until that write-back is done.
// Reset (rst_n, async, low) clears control state and loads the parameters' reset values;
// the trace store is then swept to zero, all IN_DIM*OUT_DIM entries, with item_stall high.
// The weight store is undefined until a load item writes it.
`include "three_factor_plasticity_update_macros.svh"

module three_factor_plasticity_update #(
    parameter int IN_DIM  = 64,
    parameter int OUT_DIM = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration write port
    input  logic                                cfg_wen,
    input  logic [tfpu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfpu_pkg::CFG_DATA_W-1:0]     cfg_data,

    // item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                func,
    input  logic [5:0]                          row_index,
    input  logic [5:0]                          col_index,
    input  logic signed [15:0]                  pre_value,
    input  logic signed [15:0]                  post_value,
    input  logic signed [15:0]                  post_homeostasis,
    input  logic signed [15:0]                  reward_signal,
    input  logic signed [15:0]                  load_weight,

    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [15:0]                  weight_out,
    output logic signed [31:0]                  trace_out
);

    localparam int DEPTH = IN_DIM * OUT_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
    localparam int NF    = tfpu_pkg::FRONT_N;
    localparam int RS    = NF - 1;      // memory issue stage
    localparam int NB    = 5;           // memory section depth

    // Item as it travels the front pipeline. The divider fields and the
    // scratch word are reused stage by stage; synthesis drops dead bits.
    typedef struct packed {
        logic                func;
        logic                inrange;
        logic [AW-1:0]       addr;
        logic signed [15:0]  pre;
        logic signed [15:0]  post;
        logic signed [15:0]  h;
        logic signed [15:0]  reward;
        logic signed [15:0]  loadw;
        logic signed [31:0]  pp;
        logic [15:0]         den;
        logic [15:0]         rem;
        logic [17:0]         quo;
        logic [32:0]         work;
    } front_t;

    // Item in the memory section.
    typedef struct packed {
        logic                func;
        logic                inrange;
        logic [AW-1:0]       addr;
        logic signed [15:0]  loadw;
        logic signed [31:0]  pp;
        logic signed [31:0]  mr;
    } back_t;

    // ------------------------------------------------------------------
    // Configuration registers (user writes only while the block is idle; not enforced)
    // ------------------------------------------------------------------
    logic [16:0] trace_decay_reg;
    logic [15:0] learn_rate_reg;
    logic [15:0] decay_rate_reg;
    logic [14:0] clip_limit_reg;
    logic [14:0] homeo_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_decay_reg <= tfpu_pkg::TRACE_DECAY_RST;
            learn_rate_reg  <= tfpu_pkg::LEARN_RATE_RST;
            decay_rate_reg  <= tfpu_pkg::DECAY_RATE_RST;
            clip_limit_reg  <= tfpu_pkg::CLIP_LIMIT_RST;
            homeo_max_reg   <= tfpu_pkg::HOMEO_MAX_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                tfpu_pkg::REG_TRACE_DECAY: trace_decay_reg <= cfg_data[16:0];
                tfpu_pkg::REG_LEARN_RATE:  learn_rate_reg  <= cfg_data[15:0];
                tfpu_pkg::REG_DECAY_RATE:  decay_rate_reg  <= cfg_data[15:0];
                tfpu_pkg::REG_CLIP_LIMIT:  clip_limit_reg  <= cfg_data[14:0];
                tfpu_pkg::REG_HOMEO_MAX:   homeo_max_reg   <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Trace store clearing sweep after reset
    // ------------------------------------------------------------------
    logic          clear_active_reg;
    logic [AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            if (clear_addr_reg == ADDR_LAST)
            begin
                clear_active_reg <= 1'b0;
            end
            else
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline enables
    // ------------------------------------------------------------------
    logic   result_valid_reg;
    logic   adv;            // memory section and output register move
    logic   hazard;         // issue stage must wait for a write-back
    logic   f_adv;          // front pipeline moves
    logic   f_valid_reg [NF];
    front_t f_stage_reg [NF];

    // The output register parts the result side from the pipeline: with it
    // empty or being taken, the memory section moves every cycle.
    assign adv   = !result_valid_reg || !result_stall;
    assign f_adv = !f_valid_reg[RS] || (adv && !hazard);
    assign item_stall = clear_active_reg || !f_adv;

    // ------------------------------------------------------------------
    // Front pipeline: address, pre*post, gate divider, rate and reward
    // ------------------------------------------------------------------
    front_t in_item;
    logic [31:0] addr_wide;

    always_comb
    begin
        addr_wide = 32'(row_index) * 32'(OUT_DIM) + 32'(col_index);
        in_item = '0;
        in_item.func    = func;
        in_item.inrange = (32'(row_index) < 32'(IN_DIM)) && (32'(col_index) < 32'(OUT_DIM));
        in_item.addr    = addr_wide[AW-1:0];
        in_item.pre     = pre_value;
        in_item.post    = post_value;
        in_item.h       = post_homeostasis;
        in_item.reward  = reward_signal;
        in_item.loadw   = load_weight;
    end

    // f_next[k] is the value that enters stage k+1.
    front_t f_next [NF-1];

    always_comb
    begin
        logic [14:0]        hmax;
        logic [14:0]        hpos;
        logic [16:0]        trial;
        logic [18:0]        gate_sum;
        logic [16:0]        gate;
        logic [32:0]        msum;
        logic signed [32:0] mr;
        for (int k = 0; k < NF - 1; k++)
        begin
            hmax     = '0;
            hpos     = '0;
            trial    = '0;
            gate_sum = '0;
            gate     = '0;
            msum     = '0;
            mr       = '0;
            f_next[k] = f_stage_reg[k];
            if (k == 0)
            begin
                // gate = hmax / (hmax + max(0,h)), rounded; zero hmax acts as one LSB.
                // First quotient bit is set only when h <= 0.
                hmax = (homeo_max_reg == '0) ? 15'd1 : homeo_max_reg;
                hpos = f_stage_reg[k].h[15] ? 15'd0 : f_stage_reg[k].h[14:0];
                f_next[k].den = {1'b0, hmax} + {1'b0, hpos};
                f_next[k].rem = (hpos == '0) ? 16'd0 : {1'b0, hmax};
                f_next[k].quo = {17'd0, (hpos == '0)};
                f_next[k].pp  = $signed(f_stage_reg[k].pre) * $signed(f_stage_reg[k].post);
            end
            else if (k <= tfpu_pkg::DIV_LAST)
            begin
                // restoring division, one quotient bit per stage
                trial = {f_stage_reg[k].rem, 1'b0};
                if (trial >= {1'b0, f_stage_reg[k].den})
                begin
                    f_next[k].rem = 16'(trial - {1'b0, f_stage_reg[k].den});
                    f_next[k].quo = {f_stage_reg[k].quo[16:0], 1'b1};
                end
                else
                begin
                    f_next[k].rem = trial[15:0];
                    f_next[k].quo = {f_stage_reg[k].quo[16:0], 1'b0};
                end
            end
            else if (k == tfpu_pkg::GATE_STAGE)
            begin
                // quotient carries one extra bit: round half up
                gate_sum = {1'b0, f_stage_reg[k].quo} + 19'd1;
                gate     = gate_sum[17:1];
                f_next[k].work = {17'd0, learn_rate_reg} * {16'd0, gate};
            end
            else if (k == tfpu_pkg::RATE_STAGE)
            begin
                msum = f_stage_reg[k].work + 33'd32768;
                f_next[k].work = {17'd0, msum[31:16]};
            end
            else if (k == tfpu_pkg::MR_STAGE)
            begin
                mr = $signed({1'b0, f_stage_reg[k].work[15:0]}) * $signed(f_stage_reg[k].reward);
                f_next[k].work = mr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NF; k++)
            begin
                f_valid_reg[k] <= 1'b0;
            end
        end
        else if (f_adv)
        begin
            f_valid_reg[0] <= item_valid && !clear_active_reg;
            for (int k = 1; k < NF; k++)
            begin
                f_valid_reg[k] <= f_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            f_stage_reg[0] <= in_item;
            for (int k = 1; k < NF; k++)
            begin
                f_stage_reg[k] <= f_next[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Memory issue stage and interlock
    // ------------------------------------------------------------------
    // An update may not read its synapse while an earlier item that writes
    // the same synapse is still in the memory section. The last stage
    // writes at the same edge as a read, so it counts as well.
    logic   bk_valid_reg [1:NB];
    back_t  bk_item_reg  [1:NB];
    logic   addr_busy;

    always_comb
    begin
        addr_busy = 1'b0;
        for (int s = 1; s <= NB; s++)
        begin
            if (bk_valid_reg[s] && bk_item_reg[s].inrange &&
                (bk_item_reg[s].addr == f_stage_reg[RS].addr))
            begin
                addr_busy = 1'b1;
            end
        end
        hazard = f_valid_reg[RS] && f_stage_reg[RS].inrange &&
                 (f_stage_reg[RS].func == tfpu_pkg::FUNC_UPDATE) && addr_busy;
    end

    back_t issue_item;

    always_comb
    begin
        issue_item.func    = f_stage_reg[RS].func;
        issue_item.inrange = f_stage_reg[RS].inrange;
        issue_item.addr    = f_stage_reg[RS].addr;
        issue_item.loadw   = f_stage_reg[RS].loadw;
        issue_item.pp      = f_stage_reg[RS].pp;
        issue_item.mr      = $signed(f_stage_reg[RS].work[31:0]);
    end

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    logic        wb_we;
    logic [15:0] weight_rdata;
    logic [31:0] trace_rdata;
    logic signed [15:0] w_new;
    logic signed [31:0] tr_new;
    logic        trace_we;
    logic [AW-1:0] trace_waddr;
    logic [31:0] trace_wdata;

    assign trace_we    = clear_active_reg || wb_we;
    assign trace_waddr = clear_active_reg ? clear_addr_reg : bk_item_reg[NB].addr;
    assign trace_wdata = clear_active_reg ? 32'd0 : tr_new;

    tfpu_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wb_we),
        .waddr (bk_item_reg[NB].addr),
        .wdata (w_new),
        .re    (adv),
        .raddr (f_stage_reg[RS].addr),
        .rdata (weight_rdata)
    );

    tfpu_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_trace_ram (
        .clk   (clk),
        .we    (trace_we),
        .waddr (trace_waddr),
        .wdata (trace_wdata),
        .re    (adv),
        .raddr (f_stage_reg[RS].addr),
        .rdata (trace_rdata)
    );

    // ------------------------------------------------------------------
    // Memory section: X1 read data .. X5 write-back
    // ------------------------------------------------------------------
    logic signed [49:0] x2_dprod_reg;
    logic signed [15:0] x2_wold_reg;
    logic signed [31:0] x3_tr_reg;
    logic signed [15:0] x3_wold_reg;
    logic signed [63:0] x4_mrt_reg;
    logic signed [32:0] x4_dw_reg;
    logic signed [31:0] x4_tr_reg;
    logic signed [15:0] x4_wold_reg;
    logic signed [21:0] x5_delta_reg;
    logic signed [31:0] x5_tr_reg;
    logic signed [15:0] x5_wold_reg;

    logic [16:0]        decay_eff;
    logic signed [49:0] x1_dprod;
    logic signed [50:0] x2_dsum;
    logic signed [35:0] x2_tsum;
    logic signed [31:0] x2_tr;
    logic signed [63:0] x3_mrt;
    logic signed [32:0] x3_dw;
    logic signed [64:0] x4_dw_sh;
    logic signed [64:0] x4_acc;
    logic signed [21:0] x4_delta;
    logic [14:0]        bound;
    logic signed [22:0] bound_s;
    logic signed [22:0] x5_wsum;
    logic signed [15:0] w_upd;

    // X1: decay * old trace, decay clipped to one
    always_comb
    begin
        decay_eff = (trace_decay_reg > tfpu_pkg::DECAY_ONE) ? tfpu_pkg::DECAY_ONE
                                                            : trace_decay_reg;
        x1_dprod  = $signed({1'b0, decay_eff}) * $signed(trace_rdata);
    end

    // X2: round to Q8.24, add pre*post, saturate
    always_comb
    begin
        x2_dsum = x2_dprod_reg + 51'sd32768;
        x2_tsum = $signed(x2_dsum[50:16]) + bk_item_reg[2].pp;
        if (x2_tsum > 36'sd2147483647)
        begin
            x2_tr = 32'sh7fffffff;
        end
        else if (x2_tsum < -36'sd2147483648)
        begin
            x2_tr = 32'sh80000000;
        end
        else
        begin
            x2_tr = x2_tsum[31:0];
        end
    end

    // X3: rate*reward*trace and weight decay products
    always_comb
    begin
        x3_mrt = bk_item_reg[3].mr * x3_tr_reg;
        x3_dw  = $signed({1'b0, decay_rate_reg}) * x3_wold_reg;
    end

    // X4: combine at 2^-55 and round once to Q4.12
    always_comb
    begin
        x4_dw_sh = x4_dw_reg;
        x4_acc   = x4_mrt_reg - (x4_dw_sh <<< 27) + 65'sd4398046511104;
        x4_delta = x4_acc[64:43];
    end

    // X5: new weight, clamp to +-max(0.25, clip)
    always_comb
    begin
        bound   = (clip_limit_reg > tfpu_pkg::MIN_BOUND) ? clip_limit_reg : tfpu_pkg::MIN_BOUND;
        bound_s = $signed({8'd0, bound});
        x5_wsum = x5_wold_reg + x5_delta_reg;
        if (x5_wsum > bound_s)
        begin
            w_upd = bound_s[15:0];
        end
        else if (x5_wsum < -bound_s)
        begin
            w_upd = 16'(-bound_s);
        end
        else
        begin
            w_upd = x5_wsum[15:0];
        end

        if (!bk_item_reg[NB].inrange)
        begin
            w_new  = '0;
            tr_new = '0;
        end
        else if (bk_item_reg[NB].func == tfpu_pkg::FUNC_LOAD)
        begin
            // load: stored as given, trace cleared
            w_new  = bk_item_reg[NB].loadw;
            tr_new = '0;
        end
        else
        begin
            w_new  = w_upd;
            tr_new = x5_tr_reg;
        end
    end

    assign wb_we = adv && bk_valid_reg[NB] && bk_item_reg[NB].inrange;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= NB; s++)
            begin
                bk_valid_reg[s] <= 1'b0;
            end
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            bk_valid_reg[1] <= f_valid_reg[RS] && !hazard;
            for (int s = 2; s <= NB; s++)
            begin
                bk_valid_reg[s] <= bk_valid_reg[s-1];
            end
            result_valid_reg <= bk_valid_reg[NB];
        end
    end

    logic signed [15:0] weight_out_reg;
    logic signed [31:0] trace_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bk_item_reg[1] <= issue_item;
            for (int s = 2; s <= NB; s++)
            begin
                bk_item_reg[s] <= bk_item_reg[s-1];
            end
            x2_dprod_reg   <= x1_dprod;
            x2_wold_reg    <= $signed(weight_rdata);
            x3_tr_reg      <= x2_tr;
            x3_wold_reg    <= x2_wold_reg;
            x4_mrt_reg     <= x3_mrt;
            x4_dw_reg      <= x3_dw;
            x4_tr_reg      <= x3_tr_reg;
            x4_wold_reg    <= x3_wold_reg;
            x5_delta_reg   <= x4_delta;
            x5_tr_reg      <= x4_tr_reg;
            x5_wold_reg    <= x4_wold_reg;
            weight_out_reg <= w_new;
            trace_out_reg  <= tr_new;
        end
    end

    assign result_valid = result_valid_reg;
    assign weight_out   = weight_out_reg;
    assign trace_out    = trace_out_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // interlock: an update never sits right behind a writer of its synapse
    `TFPU_ASSERT_IMPLY(a_x1_x2_distinct, clk, rst_n, bk_valid_reg[1] && bk_valid_reg[2] && bk_item_reg[1].inrange && bk_item_reg[2].inrange && (bk_item_reg[1].func == tfpu_pkg::FUNC_UPDATE), bk_item_reg[1].addr != bk_item_reg[2].addr)
    // nothing flows while the trace store is being cleared
    `TFPU_ASSERT_IMPLY(a_idle_while_clear, clk, rst_n, clear_active_reg, !f_valid_reg[0] && !bk_valid_reg[NB])
    // the sweep covers every entry
    `TFPU_ASSERT_NEXT(a_clear_runs_full, clk, rst_n, clear_active_reg && (clear_addr_reg != ADDR_LAST), clear_active_reg)

endmodule

// ----- hw/rtl/tfpu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tfpu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/three_factor_plasticity_update_tb.sv -----
// Self-checking testbench for the three-factor plasticity update block.
`timescale 1ns / 100ps

localparam int SYN_ROWS  = 64;
localparam int SYN_COLS  = 64;
localparam int SYN_TOTAL = SYN_ROWS * SYN_COLS;

typedef struct {
    logic signed [15:0] weight;
    logic signed [31:0] trace;
} synapse_result_t;

class synapse_scoreboard;
    localparam longint TRACE_MAX = 64'sh7FFF_FFFF;
    localparam longint TRACE_MIN = -TRACE_MAX - 1;

    longint trace_decay, learn_rate, decay_rate, clip_limit, homeo_max;
    logic signed [15:0] weight_mem [SYN_TOTAL];
    logic signed [31:0] trace_mem [SYN_TOTAL];
    synapse_result_t    pending_results [$];
    int                 errors;
    int                 checked;

    function new();
        trace_decay = tfpu_pkg::TRACE_DECAY_RST;
        learn_rate  = tfpu_pkg::LEARN_RATE_RST;
        decay_rate  = tfpu_pkg::DECAY_RATE_RST;
        clip_limit  = tfpu_pkg::CLIP_LIMIT_RST;
        homeo_max   = tfpu_pkg::HOMEO_MAX_RST;
        foreach (trace_mem[i])
        begin
            trace_mem[i]  = '0;
            weight_mem[i] = '0;
        end
        errors  = 0;
        checked = 0;
    endfunction

    function void set_reg(logic [tfpu_pkg::CFG_IDX_W-1:0] idx,
                          logic [tfpu_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tfpu_pkg::REG_TRACE_DECAY: trace_decay = data[16:0];
            tfpu_pkg::REG_LEARN_RATE:  learn_rate  = data[15:0];
            tfpu_pkg::REG_DECAY_RATE:  decay_rate  = data[15:0];
            tfpu_pkg::REG_CLIP_LIMIT:  clip_limit  = data[14:0];
            tfpu_pkg::REG_HOMEO_MAX:   homeo_max   = data[14:0];
            default: ;
        endcase
    endfunction

    // floor(x / 2^s + 1/2)
    function longint round_half_up(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Apply one synapse item to the shadow stores and queue its result.
    function void note_item(logic fn, logic [5:0] row, logic [5:0] col,
                            logic signed [15:0] pre, logic signed [15:0] post,
                            logic signed [15:0] homeo, logic signed [15:0] reward,
                            logic signed [15:0] loadw);
        int              addr;
        longint          decay, hmax, hpos, bound, den, gate, rate, acc, tr, w;
        synapse_result_t r;
        addr = int'(row) * SYN_COLS + int'(col);
        if (fn == tfpu_pkg::FUNC_LOAD)
        begin
            w  = longint'(loadw);
            tr = 0;
        end
        else
        begin
            decay = (trace_decay > tfpu_pkg::DECAY_ONE) ? longint'(tfpu_pkg::DECAY_ONE)
                                                         : trace_decay;
            hmax  = (homeo_max == 0) ? 1 : homeo_max;
            hpos  = (homeo > 0) ? longint'(homeo) : 0;
            bound = (clip_limit > tfpu_pkg::MIN_BOUND) ? clip_limit
                                                        : longint'(tfpu_pkg::MIN_BOUND);
            den   = hmax + hpos;
            gate  = (hmax * 65536 * 2 + den) / (2 * den);
            rate  = round_half_up(learn_rate * gate, 16);

            tr = round_half_up(decay * longint'(trace_mem[addr]), 16)
               + longint'(pre) * longint'(post);
            tr = clamp(tr, TRACE_MIN, TRACE_MAX);

            w   = longint'(weight_mem[addr]);
            acc = rate * longint'(reward) * tr - decay_rate * w * (longint'(1) <<< 27);
            w   = clamp(w + round_half_up(acc, 43), -bound, bound);
        end
        weight_mem[addr] = w[15:0];
        trace_mem[addr]  = tr[31:0];
        r.weight = w[15:0];
        r.trace  = tr[31:0];
        pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] w, logic signed [31:0] t);
        synapse_result_t exp_r;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result, weight_out %0d trace_out %0d", $time, w, t);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        checked++;
        if (w !== exp_r.weight)
        begin
            $display("%0t: weight_out mismatch, expected %0d, got %0d",
                     $time, exp_r.weight, w);
            errors++;
        end
        if (t !== exp_r.trace)
        begin
            $display("%0t: trace_out mismatch, expected %0d, got %0d",
                     $time, exp_r.trace, t);
            errors++;
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module three_factor_plasticity_update_tb;

    // A trace clear sweep after reset stalls the input over SYN_TOTAL entries;
    // the limit covers that with a wide margin over any legal stall or latency.
    localparam int QUIET_LIMIT  = 20000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 229;
    localparam int HOT_SET      = 8;
    // covers the result latency plus a read-after-write hold
    localparam int SETTLE_CYCLES = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_wen   = 1'b0;
    logic [tfpu_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [tfpu_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    logic               item_valid       = 1'b0;
    logic               item_stall;
    logic               func             = tfpu_pkg::FUNC_UPDATE;
    logic [5:0]         row_index        = '0;
    logic [5:0]         col_index        = '0;
    logic signed [15:0] pre_value        = '0;
    logic signed [15:0] post_value       = '0;
    logic signed [15:0] post_homeostasis = '0;
    logic signed [15:0] reward_signal    = '0;
    logic signed [15:0] load_weight      = '0;

    logic               result_valid;
    logic               result_stall     = 1'b0;
    logic signed [15:0] weight_out;
    logic signed [31:0] trace_out;

    synapse_scoreboard sb = new();

    // entries whose weight has been written; updates only ever target these
    bit loaded [SYN_TOTAL];
    int hot_addr [HOT_SET];
    int phase_idle [PHASES] = '{15, 30, 0, 10, 25, 5, 40, 0};

    int idle_pct    = 0;   // percent chance of a burst, per result cycle or per item
    int quiet_cycles = 0;
    int stall_left  = 0;
    int n_loads     = 0;
    int n_updates   = 0;
    int n_settings  = 0;

    three_factor_plasticity_update #(
        .IN_DIM  (SYN_ROWS),
        .OUT_DIM (SYN_COLS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .func             (func),
        .row_index        (row_index),
        .col_index        (col_index),
        .pre_value        (pre_value),
        .post_value       (post_value),
        .post_homeostasis (post_homeostasis),
        .reward_signal    (reward_signal),
        .load_weight      (load_weight),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .weight_out       (weight_out),
        .trace_out        (trace_out)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: check each transfer, then decide the stall for the next cycle.
    // DUT outputs and result_stall are read at the edge, before any update lands.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(weight_out, trace_out);
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left   <= $urandom_range(0, 14);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transfer for %0d cycles, run stopped", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Random activity value, biased toward the range ends and zero.
    function automatic logic signed [15:0] pick_activity();
        logic signed [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = '0;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // One item transfer: optional idle burst, then hold the payload until taken.
    task automatic send_item(logic fn, logic [5:0] row, logic [5:0] col,
                             logic signed [15:0] pre, logic signed [15:0] post,
                             logic signed [15:0] homeo, logic signed [15:0] reward,
                             logic signed [15:0] loadw);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item_valid       <= 1'b1;
        func             <= fn;
        row_index        <= row;
        col_index        <= col;
        pre_value        <= pre;
        post_value       <= post;
        post_homeostasis <= homeo;
        reward_signal    <= reward;
        load_weight      <= loadw;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(fn, row, col, pre, post, homeo, reward, loadw);
        if (fn == tfpu_pkg::FUNC_LOAD)
        begin
            loaded[int'(row) * SYN_COLS + int'(col)] = 1'b1;
            n_loads++;
        end
        else
            n_updates++;
    endtask

    // Wait until every queued result has come back.
    task automatic wait_for_drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [tfpu_pkg::CFG_IDX_W-1:0] idx,
                             logic [tfpu_pkg::CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Program all five registers back to back; only called with the block idle.
    task automatic program_regs(logic [16:0] decay, logic [15:0] lrate,
                                logic [15:0] wdecay, logic [14:0] clip,
                                logic [14:0] hmax);
        write_reg(tfpu_pkg::REG_TRACE_DECAY, 17'(decay));
        write_reg(tfpu_pkg::REG_LEARN_RATE,  17'(lrate));
        write_reg(tfpu_pkg::REG_DECAY_RATE,  17'(wdecay));
        write_reg(tfpu_pkg::REG_CLIP_LIMIT,  17'(clip));
        write_reg(tfpu_pkg::REG_HOMEO_MAX,   17'(hmax));
        cfg_wen <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // Mostly update traffic with random content. Half of the items hit a small
    // hot set, so back-to-back updates of one synapse run into the memory
    // read-modify-write hold and the trace accumulates to saturation.
    task automatic run_random_phase(int count);
        int                 addr;
        logic               fn;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                addr = hot_addr[$urandom_range(0, HOT_SET - 1)];
            else
                addr = $urandom_range(0, SYN_TOTAL - 1);
            // first touch must be a load; otherwise an occasional reload
            if (!loaded[addr] || $urandom_range(0, 9) == 0)
                fn = tfpu_pkg::FUNC_LOAD;
            else
                fn = tfpu_pkg::FUNC_UPDATE;
            send_item(fn, 6'(addr / SYN_COLS), 6'(addr % SYN_COLS),
                      pick_activity(), pick_activity(), pick_activity(),
                      pick_activity(), pick_activity());
        end
        item_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings. The block holds off input while
        // it clears the trace store; send_item just waits that out.
        idle_pct = 15;
        // corners get weight extremes, zero and one LSB (stored without clamp)
        send_item(tfpu_pkg::FUNC_LOAD, 6'd0,  6'd0,  0, 0, 0, 0, 16'sh7FFF);
        send_item(tfpu_pkg::FUNC_LOAD, 6'd63, 6'd63, 0, 0, 0, 0, 16'sh8000);
        send_item(tfpu_pkg::FUNC_LOAD, 6'd0,  6'd63, 0, 0, 0, 0, 16'sd0);
        send_item(tfpu_pkg::FUNC_LOAD, 6'd63, 6'd0,  0, 0, 0, 0, 16'sd1);
        // largest positive product twice: weight clamps, trace builds up
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd0, 6'd0, 16'sh8000, 16'sh8000, 16'sd0,
                  16'sh7FFF, 0);
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd0, 6'd0, 16'sh8000, 16'sh8000, 16'sd0,
                  16'sh7FFF, 0);
        // strong homeostasis shrinks the gate
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd0, 6'd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                  16'sh8000, 0);
        // negative products three times: negative trace saturation
        repeat (3)
            send_item(tfpu_pkg::FUNC_UPDATE, 6'd63, 6'd63, 16'sh7FFF, 16'sh8000,
                      16'sh8000, 16'sh8000, 0);
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd0,  6'd63, 0, 0, 16'sh7FFF, 0, 0);
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd63, 6'd0,  16'sd1, -16'sd1, 16'sd1,
                  16'sd1, 0);
        // reload clears the accumulated trace
        send_item(tfpu_pkg::FUNC_LOAD,   6'd0, 6'd0, 0, 0, 0, 0, -16'sd1);
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd0, 6'd0, 16'sd4096, 16'sd4096, 16'sd4096,
                  16'sd16384, 0);
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd0, 6'd63, 16'sh8000, 16'sh8000, -16'sd1,
                  16'sh8000, 0);
        // out-of-bound weight meets a zero reward: clamp alone
        send_item(tfpu_pkg::FUNC_LOAD,   6'd42, 6'd21, 0, 0, 0, 0, 16'sh8000);
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd42, 6'd21, -16'sd1, -16'sd1, 16'sh7FFF,
                  0, 0);
        send_item(tfpu_pkg::FUNC_LOAD,   6'd21, 6'd42, 0, 0, 0, 0, 16'sd1024);
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd21, 6'd42, 16'sd12345, -16'sd5432,
                  16'sd100, 16'sh7FFF, 0);
        send_item(tfpu_pkg::FUNC_UPDATE, 6'd21, 6'd42, 16'sh7FFF, 16'sh7FFF,
                  16'sh7FFF, 16'sh7FFF, 0);
        item_valid <= 1'b0;

        // Random phases, each under its own register setting. Extremes come
        // first: unit decay with the top rate, decay above one with a zero
        // gate scale and a clip under the floor, then weight decay alone.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_drain();
            case (p)
                0: program_regs(tfpu_pkg::DECAY_ONE, 16'hFFFF, 16'h0000, 15'h7FFF, 15'd1);
                1: program_regs(17'h1FFFF, 16'hFFFF, 16'hFFFF, 15'd0, 15'd0);
                2: program_regs(17'd0, 16'd0, 16'hFFFF, 15'd500, 15'h7FFF);
                PHASES - 1:
                    program_regs(tfpu_pkg::TRACE_DECAY_RST, tfpu_pkg::LEARN_RATE_RST,
                                 tfpu_pkg::DECAY_RATE_RST, tfpu_pkg::CLIP_LIMIT_RST,
                                 tfpu_pkg::HOMEO_MAX_RST);
                default:
                    program_regs(17'($urandom_range(0, 131071)),
                                 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 4095)),
                                 15'($urandom_range(0, 32767)),
                                 15'($urandom_range(0, 32767)));
            endcase
            idle_pct = phase_idle[p];
            foreach (hot_addr[i])
                hot_addr[i] = $urandom_range(0, SYN_TOTAL - 1);
            run_random_phase(PHASE_ITEMS);
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d loads and %0d updates under %0d register settings,",
                 n_loads, n_updates, n_settings + 1);
        $display("with %0d results compared and %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
